### src/cts_pkg.sv
package cts_pkg;

    // Widths of the ports and the datapath
    localparam int ANGLE_W = 15;
    localparam int COUNT_W = 5;
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 14;
    localparam int X2_W    = 28;
    localparam int PROD_W  = 64;

    // Reset value of term_count and default cap on the number of terms
    localparam logic [COUNT_W-1:0] TERM_COUNT_RESET  = 5'd8;
    localparam int                 MAX_TERMS_DEFAULT = 16;

    // Input angle limit: 180 degrees in 1/64 degree units
    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd11520;
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd11520;

    // (pi/11520)^2 * 2^56 = 2^32 + K2_LO
    localparam logic [31:0] K2_LO = 32'd1063919027;

    // Fixed-point constants
    localparam logic signed [VALUE_W-1:0] Q24_ONE = 32'sh0100_0000;
    localparam logic signed [VALUE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic [PROD_W-1:0] HALF_Q32 = 64'h0000_0000_8000_0000;
    localparam logic [PROD_W-1:0] HALF_Q24 = 64'h0000_0000_0080_0000;

    // round(2^32 / ((2i-1)(2i))), indexed by i; entry 0 unused
    localparam logic [31:0] RECIP_TABLE [32] = '{
        32'd0,          32'd2147483648, 32'd357913941,  32'd143165577,
        32'd76695845,   32'd47721859,   32'd32537631,   32'd23598721,
        32'd17895697,   32'd14035841,   32'd11302546,   32'd9296466,
        32'd7780738,    32'd6607642,    32'd5681174,    32'd4936744,
        32'd4329604,    32'd3827957,    32'd3408704,    32'd3054742,
        32'd2753184,    32'd2494174,    32'd2270067,    32'd2074863,
        32'd1903798,    32'd1753048,    32'd1619520,    32'd1500687,
        32'd1394470,    32'd1299143,    32'd1213268,    32'd1135634
    };

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_X2,
        ST_TMUL,
        ST_TUPD,
        ST_ACC,
        ST_DONE
    } cts_state_t;

endpackage

### src/cosine_taylor_series.sv
// Cosine by its Maclaurin series, Q8.24 result.
// Input channel: angle_deg (1/64 degree, clamped to +/-180 degrees) moves on
// in_valid/in_ready. Output channel: cos_value and saturated move on
// out_valid/out_ready. term_count is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, as the block does not enforce this.
// term_count resets to 8 and is capped to MAX_TERMS (at most 31); zero acts as 1.
// One 32x32 multiply-add unit with a registered product does all the multiplications:
// three passes form the angle squared, then each further term takes two passes
// (scaled reciprocal factor, then term times factor), and a final step adds
// the last term into the sum.
// The block works on one item at a time: in_ready is high only in idle, which
// is entered in the cycle after a result is loaded.
// The result sits in an output register: a stalled receiver does not stop the
// next item from being accepted and computed; only the load of the following
// result waits until the held one is transferred.
// Reset (asynchronous, rst_n low) returns the sequencer to idle, drops out_valid
// and sets term_count to 8.
module cosine_taylor_series #(
    parameter int MAX_TERMS = cts_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cts_pkg::COUNT_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [cts_pkg::ANGLE_W-1:0]  angle_deg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [cts_pkg::VALUE_W-1:0]  cos_value,
    output logic                                saturated
);
    import cts_pkg::*;

    localparam int TermCap = (MAX_TERMS > 31) ? 31 : MAX_TERMS;
    localparam logic [COUNT_W-1:0] TermCapW = COUNT_W'(TermCap);

    cts_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        term_count_reg;
    logic [COUNT_W-1:0]        n_reg, n_next;
    logic [COUNT_W-1:0]        idx_reg, idx_next;
    logic [MAG_W-1:0]          mag_reg, mag_next;
    logic [X2_W-1:0]           x2_reg, x2_next;
    logic signed [VALUE_W-1:0] term_reg, term_next;
    logic signed [VALUE_W-1:0] sum_reg, sum_next;
    logic                      sat_reg, sat_next;
    logic [PROD_W-1:0]         prod_reg;
    logic signed [VALUE_W-1:0] cos_value_reg;
    logic                      saturated_reg;
    logic                      out_valid_reg;
    logic                      out_load;

    logic [31:0]               mul_a;
    logic [31:0]               mul_b;
    logic [PROD_W-1:0]         mul_add;

    logic signed [ANGLE_W-1:0] ang_clamped;
    logic signed [ANGLE_W-1:0] ang_abs;
    logic [COUNT_W-1:0]        n_eff;
    logic [31:0]               term_mag;
    logic [39:0]               p_val;
    logic signed [VALUE_W-1:0] term_upd;
    logic                      term_sat;
    logic signed [VALUE_W:0]   sum_ext;
    logic signed [VALUE_W-1:0] sum_upd;
    logic                      sum_sat;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TERM_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            term_count_reg <= cfg_wdata;
        end
    end

    // Clamp the angle and take its magnitude
    always_comb
    begin
        if (angle_deg > ANGLE_MAX)
        begin
            ang_clamped = ANGLE_MAX;
        end
        else if (angle_deg < ANGLE_MIN)
        begin
            ang_clamped = ANGLE_MIN;
        end
        else
        begin
            ang_clamped = angle_deg;
        end
        ang_abs = ang_clamped[ANGLE_W-1] ? -ang_clamped : ang_clamped;
    end

    // Limit the term count to 1 .. cap
    always_comb
    begin
        if (term_count_reg == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (term_count_reg > TermCapW)
        begin
            n_eff = TermCapW;
        end
        else
        begin
            n_eff = term_count_reg;
        end
    end

    // Term magnitude, next term with clamp
    always_comb
    begin
        term_mag = term_reg[VALUE_W-1] ? 32'(-term_reg) : 32'(term_reg);
        p_val    = prod_reg[63:24];
        term_sat = 1'b0;
        if (term_reg[VALUE_W-1])
        begin
            // new term is positive
            if (p_val > 40'h00_7FFF_FFFF)
            begin
                term_upd = S32_MAX;
                term_sat = 1'b1;
            end
            else
            begin
                term_upd = signed'(p_val[31:0]);
            end
        end
        else
        begin
            // new term is negative
            if (p_val > 40'h00_8000_0000)
            begin
                term_upd = S32_MIN;
                term_sat = 1'b1;
            end
            else
            begin
                term_upd = signed'(32'(-p_val[32:0]));
            end
        end
    end

    // Add the latest term into the sum with clamp
    always_comb
    begin
        sum_ext = {sum_reg[VALUE_W-1], sum_reg} + {term_reg[VALUE_W-1], term_reg};
        sum_sat = 1'b0;
        if (sum_ext[VALUE_W] != sum_ext[VALUE_W-1])
        begin
            sum_sat = 1'b1;
            sum_upd = sum_ext[VALUE_W] ? S32_MIN : S32_MAX;
        end
        else
        begin
            sum_upd = sum_ext[VALUE_W-1:0];
        end
    end

    // Shared multiply-add unit with registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b) + mul_add;
    end

    // Sequencer state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        mag_reg  <= mag_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        sum_reg  <= sum_next;
        sat_reg  <= sat_next;
    end

    // Next state, multiplier operands and datapath updates
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        mag_next   = mag_reg;
        x2_next    = x2_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        sat_next   = sat_reg;
        mul_a      = '0;
        mul_b      = '0;
        mul_add    = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mag_next   = ang_abs[MAG_W-1:0];
                    n_next     = n_eff;
                    idx_next   = '0;
                    term_next  = Q24_ONE;
                    sum_next   = Q24_ONE;
                    sat_next   = 1'b0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                // a^2
                mul_a      = 32'(mag_reg);
                mul_b      = 32'(mag_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // a^2 * K2 + half, with the top bit of K2 folded into the addend
                mul_a      = {5'd0, prod_reg[26:0]};
                mul_b      = K2_LO;
                mul_add    = {5'd0, prod_reg[26:0], 32'h8000_0000};
                state_next = ST_X2;
            end
            ST_X2:
            begin
                x2_next = prod_reg[59:32];
                if (n_reg == COUNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // first factor: x^2 * r_1
                    mul_a      = {4'd0, prod_reg[59:32]};
                    mul_b      = RECIP_TABLE[1];
                    mul_add    = HALF_Q32;
                    idx_next   = COUNT_W'(1);
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL:
            begin
                // |term| * f_i, and fold the previous term into the sum
                mul_a   = term_mag;
                mul_b   = {4'd0, prod_reg[59:32]};
                mul_add = HALF_Q24;
                if (idx_reg > COUNT_W'(1))
                begin
                    sum_next = sum_upd;
                    sat_next = sat_reg | sum_sat;
                end
                state_next = ST_TUPD;
            end
            ST_TUPD:
            begin
                term_next = term_upd;
                sat_next  = sat_reg | term_sat;
                if (idx_reg == n_reg - COUNT_W'(1))
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    // next factor while the term settles
                    mul_a      = {4'd0, x2_reg};
                    mul_b      = RECIP_TABLE[idx_reg + COUNT_W'(1)];
                    mul_add    = HALF_Q32;
                    idx_next   = idx_reg + COUNT_W'(1);
                    state_next = ST_TMUL;
                end
            end
            ST_ACC:
            begin
                sum_next   = sum_upd;
                sat_next   = sat_reg | sum_sat;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cos_value_reg <= sum_reg;
            saturated_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign cos_value = cos_value_reg;
    assign saturated = saturated_reg;

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SQUARE))
        else $error("accepted item did not start the square pass");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TMUL || state_reg == ST_TUPD) |->
            (idx_reg != '0 && idx_reg < n_reg))
        else $error("term index out of range");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (n_reg != '0 && n_reg <= TermCapW))
        else $error("term count out of range during an item");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside the done state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_DONE) |=>
            (state_reg == ST_DONE))
        else $error("pending result overwritten");

endmodule
